>>> src/mffd_pkg.sv
package mffd_pkg;

  // Frame layout
  localparam int unsigned FrameLen  = 10;
  localparam int unsigned HeldBytes = 8;
  localparam logic [3:0]  IdleCount = 4'd10;
  localparam logic [3:0]  LastIdx   = 4'd9;
  localparam logic [3:0]  CrcIdx    = 4'd8;

  // Checksum: reflected CRC-8/MAXIM
  localparam logic [7:0] CrcPoly = 8'h8c;
  localparam logic [7:0] CrcInit = 8'h00;

  // Type bytes carried in frame byte 1
  localparam logic [7:0] TypeSpeed   = 8'h64;
  localparam logic [7:0] TypeOdom    = 8'h74;
  localparam logic [7:0] TypeMode    = 8'h75;
  localparam logic [7:0] TypeModeAck = 8'ha0;

  typedef enum logic [2:0] {
    FT_SPEED   = 3'd0,
    FT_ODOM    = 3'd1,
    FT_MODE    = 3'd2,
    FT_MODEACK = 3'd3,
    FT_UNKNOWN = 3'd4
  } frame_type_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic               frame_valid;
    logic               checksum_ok;
    frame_type_t        frame_type;
    logic [7:0]         motor_id;
    logic signed [15:0] speed_raw;
    logic signed [15:0] current_raw;
    logic [7:0]         rev_period;
    logic signed [7:0]  temperature;
  } out_word_t;

  // Fold one byte into the running checksum, one bit per step
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Map the type byte to its code
  function automatic frame_type_t type_code(input logic [7:0] t);
    frame_type_t ft;
    unique case (t)
      TypeSpeed:   ft = FT_SPEED;
      TypeOdom:    ft = FT_ODOM;
      TypeMode:    ft = FT_MODE;
      TypeModeAck: ft = FT_MODEACK;
      default:     ft = FT_UNKNOWN;
    endcase
    return ft;
  endfunction

endpackage

>>> src/motor_feedback_frame_decoder_top.sv
// Motor feedback frame decoder: takes one reply byte per cycle, collects a
// ten-byte frame, checks bytes 0 to 8 against byte 9 with a reflected
// CRC-8/MAXIM and gives one result word per completed frame, carrying the
// checksum status, frame type and motor id, plus speed, current, revolution
// period and temperature for a valid speed feedback frame (zero otherwise).
// Raise frame_start with byte 0; bytes after a complete frame are dropped until
// the next frame_start. A byte can be taken every cycle; the result word is
// presented in the cycle after byte 9 is accepted when the output register is
// free, otherwise it waits in a skid entry behind the word already shown. The
// eight-step CRC update on the byte path is combinational, and the input
// stalls only while both output entries hold a word.
module motor_feedback_frame_decoder_top
  import mffd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      accept;
  logic      res_valid;
  out_word_t res;
  logic      full;

  // Take a word whenever the skid stage has room
  assign in_stall = full;
  assign accept   = in_valid && !full;

  mffd_assembler u_assembler (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .word      (in_word),
    .res_valid (res_valid),
    .res       (res)
  );

  mffd_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .full      (full)
  );

endmodule

>>> src/mffd_assembler.sv
module mffd_assembler
  import mffd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_word_t  word,
  output logic      res_valid,
  output out_word_t res
);

  logic [3:0] count_r, count_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] held_r [HeldBytes];
  logic [3:0] idx;
  logic [7:0] crc_base;
  logic       ok;
  logic       speed;
  frame_type_t ft;

  // Position of this word in the frame
  assign idx      = word.frame_start ? 4'd0 : count_r;
  assign crc_base = (idx == 4'd0) ? CrcInit : crc_r;

  // Advance count and checksum
  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    if (accept) begin
      if (idx < LastIdx) begin
        crc_nxt   = crc_update(crc_base, word.rx_byte);
        count_nxt = idx + 4'd1;
      end else begin
        count_nxt = IdleCount;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 4'd0;
      crc_r   <= CrcInit;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // Hold frame bytes 0 to 7
  always_ff @(posedge clk) begin
    if (accept && idx < CrcIdx) begin
      held_r[idx[2:0]] <= word.rx_byte;
    end
  end

  // Check and decode on the last word
  assign ok        = (crc_r == word.rx_byte);
  assign ft        = type_code(held_r[1]);
  assign speed     = ok && (ft == FT_SPEED);
  assign res_valid = accept && (idx == LastIdx);

  always_comb begin
    res             = '0;
    res.checksum_ok = ok;
    res.frame_type  = ft;
    res.frame_valid = ok && (ft != FT_UNKNOWN);
    res.motor_id    = held_r[0];
    if (speed) begin
      res.speed_raw   = {held_r[2], held_r[3]};
      res.current_raw = {held_r[4], held_r[5]};
      res.rev_period  = held_r[6];
      res.temperature = held_r[7];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IdleCount)
    else $error("byte count beyond idle value");

  a_rest_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> count_r == IdleCount)
    else $error("count not parked after last word");

  a_speed_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !(res.frame_valid && res.frame_type == FT_SPEED)
      |-> res.speed_raw == 16'sd0 && res.current_raw == 16'sd0
          && res.rev_period == 8'd0 && res.temperature == 8'sd0)
    else $error("speed fields set outside valid speed frame");

endmodule

>>> src/mffd_out_skid.sv
module mffd_out_skid
  import mffd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  out_word_t res,
  input  logic      out_stall,
  output logic      out_valid,
  output out_word_t out_word,
  output logic      full
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  out_word_t skid_word_r, skid_word_nxt;

  // Move words between result register and skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_word_nxt  = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_word_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign full      = skid_valid_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word with result register empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !skid_valid_r)
    else $error("result arrived with skid stage full");

  a_catch_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && res_valid |=> skid_valid_r)
    else $error("result dropped while output stalled");

endmodule
